>>> rtl/core/mkd_pkg.sv
// Shared types and constants for the matrix keypad debouncer.
package mkd_pkg;

    localparam int ROWS_DEF  = 5;
    localparam int COLS_DEF  = 4;
    localparam int KEY_W     = 20;
    localparam int TIME_W    = 32;
    localparam int DEB_W     = 16;
    localparam logic [DEB_W-1:0] DEB_RESET = 16'd50;

    typedef struct packed {
        logic [KEY_W-1:0]  key_levels;
        logic [TIME_W-1:0] now_ms;
    } t_scan;

    typedef struct packed {
        logic [KEY_W-1:0] press_mask;
        logic [KEY_W-1:0] release_mask;
    } t_event;

endpackage

>>> rtl/core/mkd_lane.sv
// One key lane: stored level and change time, qualify and update.
module mkd_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_level,
    input  logic [mkd_pkg::TIME_W-1:0] i_limit,
    input  logic [mkd_pkg::TIME_W-1:0] i_now,
    output logic                       o_press,
    output logic                       o_release
);
    import mkd_pkg::*;

    logic              r_level;
    logic [TIME_W-1:0] r_time;
    logic              w_accept;

    assign w_accept  = (i_level != r_level) && (i_limit > r_time);
    assign o_press   = w_accept && !i_level;
    assign o_release = w_accept && i_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_time  <= '0;
        end else if (i_en && w_accept) begin
            r_level <= i_level;
            r_time  <= i_now;
        end
    end

endmodule

>>> rtl/core/mkd_merge.sv
// Merge stage: collects lane events into the output masks register.
module mkd_merge #(
    parameter int NKEYS = mkd_pkg::ROWS_DEF * mkd_pkg::COLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NKEYS-1:0] i_press,
    input  logic [NKEYS-1:0] i_release,
    input  logic             i_ready,
    output logic             o_valid,
    output mkd_pkg::t_event  o_evt
);
    import mkd_pkg::*;

    logic   r_valid;
    t_event r_evt;
    t_event n_evt;

    // keys beyond the field width are dropped
    genvar g;
    generate
        for (g = 0; g < KEY_W; g++) begin : g_bit
            if (g < NKEYS) begin : g_on
                assign n_evt.press_mask[g]   = i_press[g];
                assign n_evt.release_mask[g] = i_release[g];
            end else begin : g_off
                assign n_evt.press_mask[g]   = 1'b0;
                assign n_evt.release_mask[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= n_evt;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;

endmodule

>>> rtl/core/matrix_keypad_debounce.sv
// Matrix keypad debouncer: an accepted request is registered in stage A, then in the merge stage.
// Throughput: one scan per cycle while the output is not stalled; every key has its own lane,
// so the per-key compare and update of level and change time run for all keys in parallel.
// Stage A holds the scan and its time limit, the merge stage holds the masks.
// Synchronous active-low reset: all keys released, change times zero,
// debounce time 50 ms, pipeline empty.
module matrix_keypad_debounce #(
    parameter int ROWS = mkd_pkg::ROWS_DEF,
    parameter int COLS = mkd_pkg::COLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mkd_pkg::DEB_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  mkd_pkg::t_scan            i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mkd_pkg::t_event           o_out
);
    import mkd_pkg::*;

    localparam int NKEYS = ROWS * COLS;

    logic [DEB_W-1:0]  r_debounce;
    logic              r_a_valid;
    logic [NKEYS-1:0]  r_a_levels;
    logic [TIME_W-1:0] r_a_limit;
    logic [TIME_W-1:0] r_a_now;

    logic [NKEYS-1:0]  n_levels;
    logic [NKEYS-1:0]  w_press;
    logic [NKEYS-1:0]  w_release;
    logic              w_adv;
    logic              w_take;

    assign w_adv      = r_a_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    // keys past the field width read as pressed
    genvar g;
    generate
        for (g = 0; g < NKEYS; g++) begin : g_lvl
            if (g < KEY_W) begin : g_in
                assign n_levels[g] = i_in.key_levels[g];
            end else begin : g_zero
                assign n_levels[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEB_RESET;
            r_a_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_data;
            end
            if (w_take) begin
                r_a_valid <= 1'b1;
            end else if (w_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_levels <= n_levels;
            r_a_limit  <= i_in.now_ms - TIME_W'(r_debounce);
            r_a_now    <= i_in.now_ms;
        end
    end

    generate
        for (g = 0; g < NKEYS; g++) begin : g_lane
            mkd_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_adv),
                .i_level   (r_a_levels[g]),
                .i_limit   (r_a_limit),
                .i_now     (r_a_now),
                .o_press   (w_press[g]),
                .o_release (w_release[g])
            );
        end
    endgenerate

    mkd_merge #(
        .NKEYS (NKEYS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_adv),
        .i_press   (w_press),
        .i_release (w_release),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_evt     (o_out)
    );

endmodule

>>> bench/matrix_keypad_debounce_test.sv
// Self-checking bench for the keypad debouncer: random scans with bursty flow, predicted masks.
module matrix_keypad_debounce_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mkd_pkg::*;

    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_COIN,
        RDY_THIRD,
        RDY_SPARSE
    } rdy_mode_e;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 244;
    localparam int DRAIN_CYCLES = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [DEB_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    t_scan            in_scan = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_event           out_event;

    // debouncer state as the bench sees it
    logic [DEB_W-1:0]  deb_ms = DEB_RESET;
    logic [KEY_W-1:0]  key_state = '1;
    logic [TIME_W-1:0] key_stamp [KEY_W] = '{default: '0};

    // stimulus generator state
    logic [TIME_W-1:0] ms_clock = '0;
    logic [KEY_W-1:0]  cur_levels = '1;

    t_scan  scan_q [$];
    t_event event_q [$];

    int        errors = 0;
    int        gap_left = 0;
    int        burst_left = 8;
    int        stall_left = 0;
    int        cyc = 0;
    rdy_mode_e stall_mode = RDY_FULL;

    matrix_keypad_debounce dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_scan),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_event)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Qualify every key against its own change time; updates the bench state.
    function automatic t_event debounce_scan(input t_scan s);
        logic [TIME_W-1:0] lim;
        t_event            ev;
        int                k;
        lim = s.now_ms - TIME_W'(deb_ms);
        ev  = '0;
        for (k = 0; k < KEY_W; k++) begin
            if (s.key_levels[k] != key_state[k] && lim > key_stamp[k]) begin
                key_state[k] = s.key_levels[k];
                key_stamp[k] = s.now_ms;
                if (s.key_levels[k] == 1'b0) begin
                    ev.press_mask[k] = 1'b1;
                end else begin
                    ev.release_mask[k] = 1'b1;
                end
            end
        end
        return ev;
    endfunction

    // Mostly a running clock with a few keys toggling; some bounce and stale times.
    function automatic t_scan next_scan(input logic [DEB_W-1:0] deb, input bit wild);
        t_scan       s;
        int unsigned roll;
        int unsigned span;
        int unsigned nflip;
        roll     = $urandom_range(0, 99);
        span     = deb + deb / 2 + 2;
        ms_clock = ms_clock + $urandom_range(0, span);
        if (wild && roll < 4) begin
            s.key_levels = KEY_W'($urandom());
            s.now_ms     = $urandom();
        end else if (roll < 10) begin
            s.key_levels = KEY_W'($urandom());
            s.now_ms     = ms_clock;
        end else if (roll < 15) begin
            // stale time never moves a stamp past the running clock
            s.key_levels = KEY_W'($urandom());
            s.now_ms     = $urandom_range(0, ms_clock);
        end else begin
            if ($urandom_range(0, 9) < 6) begin
                nflip = $urandom_range(1, 3);
                repeat (nflip) cur_levels[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
            end
            s.key_levels = cur_levels;
            s.now_ms     = ms_clock;
        end
        return s;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                event_q.push_back(debounce_scan(in_scan));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (scan_q.size() > 0) begin
                    in_scan  <= scan_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk) begin
        t_event exp_ev;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (event_q.size() == 0) begin
                    $error("result with no request pending: press_mask=%05h release_mask=%05h",
                           out_event.press_mask, out_event.release_mask);
                    errors = errors + 1;
                end else begin
                    exp_ev = event_q.pop_front();
                    if (out_event.press_mask !== exp_ev.press_mask) begin
                        $error("press_mask: expected %05h, got %05h",
                               exp_ev.press_mask, out_event.press_mask);
                        errors = errors + 1;
                    end
                    if (out_event.release_mask !== exp_ev.release_mask) begin
                        $error("release_mask: expected %05h, got %05h",
                               exp_ev.release_mask, out_event.release_mask);
                        errors = errors + 1;
                    end
                end
            end
            cyc <= cyc + 1;
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else begin
                stall_mode <= rdy_mode_e'($urandom_range(0, 3));
                stall_left <= $urandom_range(16, 160);
            end
            case (stall_mode)
                RDY_FULL:  out_ready <= 1'b1;
                RDY_COIN:  out_ready <= 1'($urandom_range(0, 1));
                RDY_THIRD: out_ready <= (cyc % 3 == 0);
                default:   out_ready <= ($urandom_range(0, 23) == 0);
            endcase
        end
    end

    initial begin
        #5_000_000;
        $display("matrix_keypad_debounce_test failed");
        $finish;
    end

    initial begin
        logic [DEB_W-1:0] deb_plan [PHASES];
        logic [DEB_W-1:0] deb_val;
        int               p;
        int               n;
        deb_plan = '{16'd50, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd50, 16'hFFFF, 16'd0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset debounce time: early-after-reset wrap, exact limits, time wrap
        scan_q.push_back(t_scan'{20'hFFFFF, 32'd0});
        scan_q.push_back(t_scan'{20'h00000, 32'd50});
        scan_q.push_back(t_scan'{20'h00000, 32'd20});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'd70});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'd71});
        scan_q.push_back(t_scan'{20'h55555, 32'd200});
        scan_q.push_back(t_scan'{20'hAAAAA, 32'd251});
        scan_q.push_back(t_scan'{20'hAAAAA, 32'd252});
        scan_q.push_back(t_scan'{20'h55555, 32'd260});
        scan_q.push_back(t_scan'{20'h55555, 32'd302});
        scan_q.push_back(t_scan'{20'hFFFFE, 32'd1000});
        scan_q.push_back(t_scan'{20'h00000, 32'hFFFF_FFF0});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'hFFFF_FFFE});
        scan_q.push_back(t_scan'{20'h00001, 32'hFFFF_FFFF});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'h0000_0010});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'h0000_0030});
        scan_q.push_back(t_scan'{20'hFFFFE, 32'h0000_0031});
        scan_q.push_back(t_scan'{20'h7FFFE, 32'h0000_0100});
        scan_q.push_back(t_scan'{20'hFFFFF, 32'h0000_0200});

        ms_clock   = 32'h0000_3000;
        cur_levels = '1;

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                deb_val = (p == 4 || p == 7) ? DEB_W'($urandom_range(0, 65535)) : deb_plan[p];
                while (scan_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                cfg_we   <= 1'b1;
                cfg_data <= deb_val;
                deb_ms   = deb_val;
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            // last phase runs the clock across the 32-bit wrap
            if (p == PHASES - 1) begin
                ms_clock = 32'hFFFF_FFFF - (PHASE_ITEMS / 2) * ((deb_ms + deb_ms / 2 + 2) / 2);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                scan_q.push_back(next_scan(deb_ms, p == PHASES - 1));
            end
        end

        while (scan_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && event_q.size() == 0) begin
            $display("matrix_keypad_debounce_test passed");
        end else begin
            $display("matrix_keypad_debounce_test failed");
        end
        $finish;
    end

endmodule
